/* src/time_ordered_event_queue_assert.svh */
// ----------------------------------------------------------------------------
// time ordered event queue assertion macros
// shared property wrappers for the queue checks
// ----------------------------------------------------------------------------
`ifndef TIME_ORDERED_EVENT_QUEUE_ASSERT_SVH
`define TIME_ORDERED_EVENT_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TOEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("event queue check failed");

// next-cycle implication, disabled while in reset
`define TOEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("event queue check failed");

`endif

/* src/toeq_pkg.sv */
// ----------------------------------------------------------------------------
// toeq_pkg
// opcodes, status codes and cell command type for the event queue
// ----------------------------------------------------------------------------
package toeq_pkg;

    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_POP_FIRST = 3'd1,
        OP_POP_LAST  = 3'd2,
        OP_REMOVE_AT = 3'd3,
        OP_READ_AT   = 3'd4,
        OP_SEARCH    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic del;
    } cell_cmd_t;

endpackage

/* src/toeq_cell.sv */
// ----------------------------------------------------------------------------
// toeq_cell
// one slot of the sorted row: holds a time and a handle, shifts right on
// insert and left on removal
// ----------------------------------------------------------------------------
module toeq_cell #(
    parameter int TIME_BITS   = 32,
    parameter int HANDLE_BITS = 16,
    parameter int IDX_BITS    = 4,
    parameter int INDEX       = 0
) (
    input  logic                   clk,
    input  toeq_pkg::cell_cmd_t    cmd,
    input  logic                   occupied,
    input  logic [IDX_BITS-1:0]    del_idx,
    input  logic [TIME_BITS-1:0]   new_time,
    input  logic [HANDLE_BITS-1:0] new_handle,
    input  logic                   left_keep,
    input  logic [TIME_BITS-1:0]   left_time,
    input  logic [HANDLE_BITS-1:0] left_handle,
    input  logic [TIME_BITS-1:0]   right_time,
    input  logic [HANDLE_BITS-1:0] right_handle,
    output logic [TIME_BITS-1:0]   slot_time,
    output logic [HANDLE_BITS-1:0] slot_handle,
    output logic                   keep,
    output logic                   match
);
    import toeq_pkg::*;

    logic [TIME_BITS-1:0]   time_reg;
    logic [TIME_BITS-1:0]   time_next;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [HANDLE_BITS-1:0] handle_next;
    logic                   at_or_after_del;

    // an occupied slot whose time is not later than the new one stays put
    assign keep            = occupied && !(time_reg > new_time);
    assign match           = occupied && (handle_reg == new_handle);
    assign at_or_after_del = IDX_BITS'(INDEX) >= del_idx;

    always_comb
    begin
        time_next   = time_reg;
        handle_next = handle_reg;
        if (cmd.ins && !keep)
        begin
            // first slot past the kept run takes the new event
            if (left_keep)
            begin
                time_next   = new_time;
                handle_next = new_handle;
            end
            else
            begin
                time_next   = left_time;
                handle_next = left_handle;
            end
        end
        else if (cmd.del && at_or_after_del)
        begin
            time_next   = right_time;
            handle_next = right_handle;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg   <= time_next;
        handle_reg <= handle_next;
    end

    assign slot_time   = time_reg;
    assign slot_handle = handle_reg;

endmodule

/* src/time_ordered_event_queue.sv */
// ----------------------------------------------------------------------------
// time_ordered_event_queue
// bounded event queue kept in ascending time order in a row of shift cells
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   in_valid / in_stall  opcode, event_time, event_handle, position
//  result    out_valid/out_stall  result_time, result_handle, found, status,
//                                 entry_total
//
//  one request per cycle while in_stall is low; every cell compares against
//  the new key in parallel and shifts in the same cycle
//  the result sits in an output register from the cycle after the transfer
//  requests are stalled only while a result waits and the output is stalled
//  reset clears the entry count and output valid; slot contents need none
// ----------------------------------------------------------------------------
`include "time_ordered_event_queue_assert.svh"

module time_ordered_event_queue #(
    parameter int CAPACITY    = 16,
    parameter int TIME_BITS   = 32,
    parameter int HANDLE_BITS = 16,
    localparam int IDX_BITS   = $clog2(CAPACITY),
    localparam int CNT_BITS   = $clog2(CAPACITY + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             opcode,
    input  logic [TIME_BITS-1:0]   event_time,
    input  logic [HANDLE_BITS-1:0] event_handle,
    input  logic [IDX_BITS-1:0]    position,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [TIME_BITS-1:0]   result_time,
    output logic [HANDLE_BITS-1:0] result_handle,
    output logic                   found,
    output logic [1:0]             status,
    output logic [CNT_BITS-1:0]    entry_total
);
    import toeq_pkg::*;

    logic [TIME_BITS-1:0]   cell_time   [CAPACITY];
    logic [HANDLE_BITS-1:0] cell_handle [CAPACITY];
    logic [CAPACITY-1:0]    cell_keep;
    logic [CAPACITY-1:0]    cell_match;
    logic [CAPACITY-1:0]    cell_occ;

    logic                   accept;
    logic                   full;
    logic                   empty;
    logic                   pos_out;
    cell_cmd_t              cmd;
    cell_cmd_t              cmd_gated;
    logic [IDX_BITS-1:0]    sel_idx;
    logic                   take_entry;
    status_t                st;
    logic [CNT_BITS-1:0]    cnt_after;

    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    count_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [TIME_BITS-1:0]   rtime_reg;
    logic [HANDLE_BITS-1:0] rhandle_reg;
    logic                   found_reg;
    status_t                status_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = count_reg == CNT_BITS'(CAPACITY);
    assign empty    = count_reg == '0;
    assign pos_out  = CNT_BITS'(position) >= count_reg;

    // request decode
    always_comb
    begin
        cmd        = '0;
        sel_idx    = position;
        take_entry = 1'b0;
        st         = ST_OK;
        cnt_after  = count_reg;
        unique case (opcode)
            OP_INSERT:
            begin
                if (full)
                    st = ST_FULL;
                else
                begin
                    cmd.ins   = 1'b1;
                    cnt_after = count_reg + 1'b1;
                end
            end
            OP_POP_FIRST:
            begin
                sel_idx = '0;
                if (empty)
                    st = ST_EMPTY;
                else
                begin
                    cmd.del    = 1'b1;
                    take_entry = 1'b1;
                    cnt_after  = count_reg - 1'b1;
                end
            end
            OP_POP_LAST:
            begin
                sel_idx = IDX_BITS'(count_reg - 1'b1);
                if (empty)
                    st = ST_EMPTY;
                else
                begin
                    cmd.del    = 1'b1;
                    take_entry = 1'b1;
                    cnt_after  = count_reg - 1'b1;
                end
            end
            OP_REMOVE_AT:
            begin
                if (pos_out)
                    st = ST_EMPTY;
                else
                begin
                    cmd.del    = 1'b1;
                    take_entry = 1'b1;
                    cnt_after  = count_reg - 1'b1;
                end
            end
            OP_READ_AT:
            begin
                if (pos_out)
                    st = ST_EMPTY;
                else
                    take_entry = 1'b1;
            end
            OP_SEARCH:
            begin
                st = ST_OK;
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    assign cmd_gated = accept ? cmd : '0;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            localparam int L = (i == 0) ? 0 : i - 1;
            localparam int R = (i == CAPACITY - 1) ? i : i + 1;

            assign cell_occ[i] = CNT_BITS'(i) < count_reg;

            toeq_cell #(
                .TIME_BITS   (TIME_BITS),
                .HANDLE_BITS (HANDLE_BITS),
                .IDX_BITS    (IDX_BITS),
                .INDEX       (i)
            ) u_cell (
                .clk          (clk),
                .cmd          (cmd_gated),
                .occupied     (cell_occ[i]),
                .del_idx      (sel_idx),
                .new_time     (event_time),
                .new_handle   (event_handle),
                .left_keep    ((i == 0) ? 1'b1 : cell_keep[L]),
                .left_time    (cell_time[L]),
                .left_handle  (cell_handle[L]),
                .right_time   (cell_time[R]),
                .right_handle (cell_handle[R]),
                .slot_time    (cell_time[i]),
                .slot_handle  (cell_handle[i]),
                .keep         (cell_keep[i]),
                .match        (cell_match[i])
            );
        end
    endgenerate

    assign count_next     = accept ? cnt_after : count_reg;
    assign out_valid_next = accept || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rtime_reg   <= take_entry ? cell_time[sel_idx] : '0;
            rhandle_reg <= take_entry ? cell_handle[sel_idx] : '0;
            found_reg   <= (opcode == OP_SEARCH) && (|cell_match);
            status_reg  <= st;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_time   = rtime_reg;
    assign result_handle = rhandle_reg;
    assign found         = found_reg;
    assign status        = status_reg;
    assign entry_total   = count_reg;

    `TOEQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_BITS'(CAPACITY))
    `TOEQ_ASSERT_NEXT(a_insert_grows, clk, rst_n, accept && (opcode == OP_INSERT) && !full,
        count_reg == $past(count_reg) + 1'b1)
    `TOEQ_ASSERT_IMP(a_full_status, clk, rst_n, out_valid_reg && (status_reg == ST_FULL),
        count_reg == CNT_BITS'(CAPACITY))

    generate
        for (i = 0; i < CAPACITY - 1; i++)
        begin : g_order_chk
            // held entries stay in ascending time order
            `TOEQ_ASSERT_IMP(a_sorted, clk, rst_n, cell_occ[i + 1],
                !(cell_time[i] > cell_time[i + 1]))
        end
    endgenerate

endmodule
